// ----- hdl/udp_port_payload_filter_macros.svh -----
`ifndef UDP_PORT_PAYLOAD_FILTER_MACROS_SVH
`define UDP_PORT_PAYLOAD_FILTER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define UPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/upf_pkg.sv -----
`default_nettype none

package upf_pkg;

  localparam int MAX_FRAME_BYTES = 65536;
  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] CUTOFF_POS = POS_W'(MAX_FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

  localparam logic [15:0] MATCH_PORT_RESET = 16'd12345;

  localparam logic [POS_W-1:0] POS_ETYPE_HI = 16'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 16'd13;
  localparam logic [POS_W-1:0] POS_IHL      = 16'd14;
  localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
  localparam logic [POS_W-1:0] POS_IP_OPTS  = 16'd24;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [3:0] IHL_MIN       = 4'd5;
  localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MATCH_PORT = 1'b0;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        payload_truncated;
    logic [15:0] payload_length;
  } payload_t;

  typedef struct packed {
    logic     emit;
    payload_t data;
  } parse_result_t;

endpackage

`default_nettype wire

// ----- hdl/upf_apb_regs.sv -----
`default_nettype none

module upf_apb_regs (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [upf_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire [upf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [upf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [15:0]                      match_port
);

  logic reg_index;
  logic wr_en;

  // word index, the low two bits are the byte offset
  assign reg_index = paddr[upf_pkg::APB_ADDR_W-1];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_port <= upf_pkg::MATCH_PORT_RESET;
    end else if (wr_en && reg_index == upf_pkg::REG_MATCH_PORT) begin
      match_port <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == upf_pkg::REG_MATCH_PORT) begin
      prdata = {{(upf_pkg::APB_DATA_W-16){1'b0}}, match_port};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/upf_parser.sv -----
`default_nettype none

module upf_parser (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     step,
  input  wire upf_pkg::frame_t    item,
  input  wire [15:0]              match_port,
  output upf_pkg::parse_result_t  result
);

  logic [upf_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  port_high_byte, port_high_byte_next;
  logic [7:0]  length_high_byte, length_high_byte_next;
  logic [15:0] announced_length, announced_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic        frame_alive, frame_alive_next;
  logic        port_matched, port_matched_next;

  logic [6:0]  udp_base;
  logic [6:0]  off_port_hi, off_port_lo, off_len_hi, off_len_lo, off_data;
  logic [15:0] udp_len;
  logic [15:0] remaining_dec;
  logic        cutoff;
  logic        stop;
  logic [7:0]  b;

  assign b        = item.frame_byte;
  assign cutoff   = (byte_position == upf_pkg::CUTOFF_POS);
  assign udp_base = 7'd14 + {1'b0, header_words, 2'b00};
  assign off_port_hi = udp_base + 7'd2;
  assign off_port_lo = udp_base + 7'd3;
  assign off_len_hi  = udp_base + 7'd4;
  assign off_len_lo  = udp_base + 7'd5;
  assign off_data    = udp_base + 7'd8;
  assign udp_len       = {length_high_byte, b};
  assign remaining_dec = bytes_remaining - 16'd1;
  assign stop          = item.frame_end || cutoff;

  always_comb begin
    byte_position_next    = byte_position;
    header_words_next     = header_words;
    port_high_byte_next   = port_high_byte;
    length_high_byte_next = length_high_byte;
    announced_length_next = announced_length;
    bytes_remaining_next  = bytes_remaining;
    frame_alive_next      = frame_alive;
    port_matched_next     = port_matched;
    result                = '0;

    if (frame_alive) begin
      if (byte_position == upf_pkg::POS_ETYPE_HI && b != upf_pkg::ETYPE_IPV4_HI) begin
        frame_alive_next = 1'b0;
      end else if (byte_position == upf_pkg::POS_ETYPE_LO &&
                   b != upf_pkg::ETYPE_IPV4_LO) begin
        frame_alive_next = 1'b0;
      end else if (byte_position == upf_pkg::POS_IHL) begin
        header_words_next = b[3:0];
        if (b[3:0] < upf_pkg::IHL_MIN) begin
          frame_alive_next = 1'b0;
        end
      end else if (byte_position == upf_pkg::POS_PROTO && b != upf_pkg::PROTO_UDP) begin
        frame_alive_next = 1'b0;
      end else if (byte_position >= upf_pkg::POS_IP_OPTS) begin
        if (byte_position == {9'd0, off_port_hi}) begin
          port_high_byte_next = b;
        end else if (byte_position == {9'd0, off_port_lo}) begin
          if ({port_high_byte, b} != match_port) begin
            frame_alive_next = 1'b0;
          end else begin
            port_matched_next = 1'b1;
          end
        end else if (byte_position == {9'd0, off_len_hi}) begin
          length_high_byte_next = b;
        end else if (byte_position == {9'd0, off_len_lo}) begin
          if (udp_len < upf_pkg::UDP_HDR_LEN) begin
            frame_alive_next = 1'b0;
          end else begin
            announced_length_next = udp_len - upf_pkg::UDP_HDR_LEN;
            bytes_remaining_next  = udp_len - upf_pkg::UDP_HDR_LEN;
          end
        end else if (byte_position >= {9'd0, off_data} && port_matched &&
                     bytes_remaining != 16'd0) begin
          bytes_remaining_next            = remaining_dec;
          result.emit                     = 1'b1;
          result.data.payload_byte        = b;
          result.data.payload_last        = (remaining_dec == 16'd0) || stop;
          result.data.payload_truncated   = (remaining_dec != 16'd0) && stop;
          result.data.payload_length      = announced_length;
        end
      end
      if (cutoff) begin
        frame_alive_next = 1'b0;
      end
    end

    // end of frame returns every per-frame field to its reset value
    if (item.frame_end) begin
      byte_position_next    = '0;
      header_words_next     = '0;
      port_high_byte_next   = '0;
      length_high_byte_next = '0;
      announced_length_next = '0;
      bytes_remaining_next  = '0;
      frame_alive_next      = 1'b1;
      port_matched_next     = 1'b0;
    end else if (byte_position != upf_pkg::POS_SAT) begin
      byte_position_next = byte_position + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      header_words     <= '0;
      port_high_byte   <= '0;
      length_high_byte <= '0;
      announced_length <= '0;
      bytes_remaining  <= '0;
      frame_alive      <= 1'b1;
      port_matched     <= 1'b0;
    end else if (step) begin
      byte_position    <= byte_position_next;
      header_words     <= header_words_next;
      port_high_byte   <= port_high_byte_next;
      length_high_byte <= length_high_byte_next;
      announced_length <= announced_length_next;
      bytes_remaining  <= bytes_remaining_next;
      frame_alive      <= frame_alive_next;
      port_matched     <= port_matched_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/udp_port_payload_filter.sv -----
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+----------------------------
// frame     | in        | frame_valid / frame_stall    | frame_byte, frame_end
// payload   | out       | payload_valid / payload_stall| byte, last, truncated, length
// apb       | in        | psel / penable / pready      | match_port at address 0
//
// one frame byte is taken every cycle while frame_stall is low; a payload byte is produced after its
// frame byte is taken, from the input register through the parser into the result register
// the input register only stalls while the result register is full and stalled
// rst is synchronous: match_port returns to 12345 and the parser to the start of a frame
// a byte that yields no payload passes through the parser without using the result register
`default_nettype none

module udp_port_payload_filter (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            frame_valid,
  output logic                           frame_stall,
  input  wire upf_pkg::frame_t           frame,
  output logic                           payload_valid,
  input  wire                            payload_stall,
  output upf_pkg::payload_t              payload,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [upf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire [upf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [upf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic                   in_valid;
  upf_pkg::frame_t        in_item;
  logic                   out_free;
  logic                   advance;
  logic [15:0]            match_port;
  upf_pkg::parse_result_t result;

  upf_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .match_port (match_port)
  );

  upf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (in_item),
    .match_port (match_port),
    .result     (result)
  );

  assign out_free    = !payload_valid || !payload_stall;
  assign advance     = in_valid && out_free;
  assign frame_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!frame_stall) begin
      in_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame_stall && frame_valid) begin
      in_item <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_valid <= 1'b0;
    end else if (out_free) begin
      payload_valid <= advance && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && result.emit) begin
      payload <= result.data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/upf_checker.sv -----
`default_nettype none
`include "udp_port_payload_filter_macros.svh"

module upf_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            frame_valid,
  input wire                            frame_stall,
  input wire upf_pkg::frame_t           frame,
  input wire                            payload_valid,
  input wire                            payload_stall,
  input wire upf_pkg::payload_t         payload,
  input wire                            psel,
  input wire                            penable,
  input wire                            pwrite,
  input wire [upf_pkg::APB_ADDR_W-1:0]  paddr,
  input wire [upf_pkg::APB_DATA_W-1:0]  pwdata,
  input wire [upf_pkg::APB_DATA_W-1:0]  prdata,
  input wire                            pready
);

  `UPF_ASSERT_NEXT(a_frame_hold, frame_valid && frame_stall, frame_valid && $stable(frame), "stalled frame transaction changed")
  `UPF_ASSERT_NEXT(a_payload_hold, payload_valid && payload_stall, payload_valid && $stable(payload), "stalled payload transaction changed")
  `UPF_ASSERT_NOW(a_trunc_last, payload_valid && payload.payload_truncated, payload.payload_last, "truncated flag without last")
  `UPF_ASSERT_NOW(a_len_nonzero, payload_valid, payload.payload_length != 16'd0, "payload emitted with zero announced length")
  `UPF_ASSERT_NEXT(a_port_readback, psel && penable && pwrite && pready && paddr == '0, prdata[15:0] == $past(pwdata[15:0]), "match_port readback differs from write")

endmodule

bind udp_port_payload_filter upf_checker u_upf_checker (.*);

`default_nettype wire
